@@ design/f32fmod_pkg.sv @@
package f32fmod_pkg;

    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
    localparam logic [30:0] EXP_ALL     = 31'h7F80_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
    localparam int          SIG_W       = 24;
    localparam int          EXP_W       = 8;
    localparam int          BITCNT_W    = $clog2(SIG_W);

    typedef struct packed {
        logic [31:0] dividend_bits;
        logic [31:0] divisor_bits;
    } op_t;

    typedef struct packed {
        logic [31:0] remainder_bits;
        logic        domain_error;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic red_step;
        logic norm_step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic special;
        logic div_last;
        logic steps_zero;
        logic norm_done;
    } sts_t;

endpackage

@@ design/f32fmod_dp.sv @@
module f32fmod_dp
    import f32fmod_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  op_t  op,
    input  cmd_t cmd,
    output sts_t sts,
    output res_t res
);

    logic [SIG_W-1:0]    r_reg, r_next;
    logic [SIG_W-1:0]    mx_reg, mx_next;
    logic [SIG_W-1:0]    my_reg, my_next;
    logic [BITCNT_W-1:0] bit_reg, bit_next;
    logic [EXP_W-1:0]    steps_reg, steps_next;
    logic [EXP_W-1:0]    e_reg, e_next;
    logic                sign_reg, sign_next;
    logic                special_reg, special_next;
    logic [31:0]         spec_res_reg, spec_res_next;
    logic                spec_derr_reg, spec_derr_next;
    res_t                res_reg, res_next;

    logic [30:0]      ax, ay;
    logic [EXP_W-1:0] exn, eyn;
    logic [SIG_W:0]   trial;
    logic [SIG_W:0]   diff;
    logic [30:0]      packed_mag;

    // Operand decode and special-case result.
    always_comb
    begin
        ax  = op.dividend_bits[30:0];
        ay  = op.divisor_bits[30:0];
        exn = (ax[30:23] == '0) ? EXP_W'(1) : ax[30:23];
        eyn = (ay[30:23] == '0) ? EXP_W'(1) : ay[30:23];
        spec_derr_next = 1'b0;
        special_next   = 1'b1;
        if (ax > EXP_ALL)
        begin
            spec_res_next = op.dividend_bits | QUIET_BIT;
        end
        else if (ay > EXP_ALL)
        begin
            spec_res_next = op.divisor_bits | QUIET_BIT;
        end
        else if (ax == EXP_ALL || ay == '0)
        begin
            spec_res_next  = DEFAULT_NAN;
            spec_derr_next = 1'b1;
        end
        else if (ax < ay)
        begin
            spec_res_next = op.dividend_bits;
        end
        else
        begin
            spec_res_next = op.dividend_bits;
            special_next  = 1'b0;
        end
    end

    // Shift-subtract step: the new bit is the next dividend bit while
    // dividing, and zero while reducing over the exponent difference.
    always_comb
    begin
        trial = {r_reg, (cmd.div_step ? mx_reg[SIG_W-1] : 1'b0)};
        diff  = trial - {1'b0, my_reg};
    end

    assign packed_mag = {e_reg - EXP_W'(1), 23'b0} + {7'b0, r_reg};

    // Register updates driven by the controller commands.
    always_comb
    begin
        r_next     = r_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        bit_next   = bit_reg;
        steps_next = steps_reg;
        e_next     = e_reg;
        sign_next  = sign_reg;
        res_next   = res_reg;
        if (cmd.load)
        begin
            r_next     = '0;
            mx_next    = {(ax[30:23] != '0), ax[22:0]};
            my_next    = {(ay[30:23] != '0), ay[22:0]};
            bit_next   = BITCNT_W'(SIG_W - 1);
            steps_next = exn - eyn;
            e_next     = eyn;
            sign_next  = op.dividend_bits[31];
        end
        if (cmd.div_step || cmd.red_step)
        begin
            r_next = diff[SIG_W] ? trial[SIG_W-1:0] : diff[SIG_W-1:0];
        end
        if (cmd.div_step)
        begin
            mx_next  = {mx_reg[SIG_W-2:0], 1'b0};
            bit_next = bit_reg - BITCNT_W'(1);
        end
        if (cmd.red_step)
        begin
            steps_next = steps_reg - EXP_W'(1);
        end
        if (cmd.norm_step)
        begin
            r_next = {r_reg[SIG_W-2:0], 1'b0};
            e_next = e_reg - EXP_W'(1);
        end
        if (cmd.finish)
        begin
            if (special_reg)
            begin
                res_next.remainder_bits = spec_res_reg;
                res_next.domain_error   = spec_derr_reg;
            end
            else if (r_reg == '0)
            begin
                res_next.remainder_bits = {sign_reg, 31'b0};
                res_next.domain_error   = 1'b0;
            end
            else
            begin
                res_next.remainder_bits = {sign_reg, packed_mag};
                res_next.domain_error   = 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        bit_reg   <= bit_next;
        steps_reg <= steps_next;
        e_reg     <= e_next;
        sign_reg  <= sign_next;
        res_reg   <= res_next;
        if (cmd.load)
        begin
            spec_res_reg  <= spec_res_next;
            spec_derr_reg <= spec_derr_next;
        end
    end

    // The special flag steers the controller, so it is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            special_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            special_reg <= special_next;
        end
    end

    always_comb
    begin
        sts.special    = special_reg;
        sts.div_last   = (bit_reg == '0);
        sts.steps_zero = (steps_reg == '0);
        sts.norm_done  = r_reg[SIG_W-1] || (e_reg <= EXP_W'(1)) || (r_reg == '0);
    end

    assign res = res_reg;

endmodule

@@ design/f32fmod_ctrl.sv @@
module f32fmod_ctrl
    import f32fmod_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic op_valid,
    output logic op_stall,
    output logic res_valid,
    input  logic res_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_RED  = 3'd2;
    localparam logic [2:0] ST_NORM = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       slot_free;

    assign slot_free = !valid_reg || !res_stall;

    // Sequencing of one item: divide, reduce, normalize, write result; special cases skip to the write.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        valid_next = valid_reg && res_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.special)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (sts.div_last)
                    begin
                        state_next = ST_RED;
                    end
                end
            end
            ST_RED:
            begin
                if (sts.steps_zero)
                begin
                    state_next = ST_NORM;
                end
                else
                begin
                    cmd.red_step = 1'b1;
                end
            end
            ST_NORM:
            begin
                if (sts.norm_done)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    cmd.finish = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign op_stall  = (state_reg != ST_IDLE);
    assign res_valid = valid_reg;

endmodule

@@ design/float32_remainder_fmod_top.sv @@
// Exact binary32 fmod(x, y) with the sign of x, one item at a time. After a beat
// is taken on op, the block runs one restoring shift-subtract per cycle: 24
// steps to reduce the dividend significand by the divisor significand, then
// one step per unit of the exponent difference (up to 253), then up to 23
// steps of normalization, then the write-back. The normalization shift never
// exceeds ey - 1. NaN, infinite, zero-divisor and |x| < |y| cases skip the
// steps and go straight to the write-back. The result sits in an output
// register, so a beat can be taken while the prior result waits.
module float32_remainder_fmod_top
    import f32fmod_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic op_valid,
    output logic op_stall,
    input  op_t  op,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    cmd_t cmd;
    sts_t sts;

    f32fmod_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    f32fmod_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .cmd   (cmd),
        .sts   (sts),
        .res   (res)
    );

`ifndef SYNTHESIS
    // A taken beat makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && !op_stall) |=> op_stall)
        else $error("input not stalled after accept");

    // A domain error always carries the default NaN.
    a_derr_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.domain_error) |-> (res.remainder_bits == DEFAULT_NAN))
        else $error("domain error without default NaN");

    // Only one command at a time reaches the datapath.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("conflicting datapath commands");
`endif

endmodule
